@@ rtl/core/qwc_pkg.sv @@
package qwc_pkg;

  localparam int QUAD_BYTES     = 16;
  localparam int PAGE_BYTES     = 8192;
  localparam int PAGES_PER_BANK = 128;

  localparam int NUM_CFG    = 7;
  localparam int CFG_IDX_W  = $clog2(NUM_CFG);
  localparam int REG_W      = 32;
  localparam int QUAD_SHIFT = $clog2(QUAD_BYTES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int START_W    = REG_W - PAGE_SHIFT;
  localparam int PAGES_W    = REG_W + 1 - PAGE_SHIFT;
  localparam int SUM_W      = PAGES_W + 1;
  localparam int FIRST_W    = 7;
  localparam int COUNT_W    = 8;
  localparam int NUM_RES    = 3;
  localparam int RES_CNT_W  = $clog2(NUM_RES + 1);
  localparam int RES_IDX_W  = $clog2(NUM_RES);

  typedef enum logic [1:0] {
    FUNC_PROG  = 2'd0,
    FUNC_FLUSH = 2'd1,
    FUNC_ERASE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_PROG  = 2'd0,
    KIND_ERASE = 2'd1,
    KIND_ERR   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLASH_START = 3'd0,
    CFG_META_BASE   = 3'd1,
    CFG_META_SIZE   = 3'd2,
    CFG_SLOT0_BASE  = 3'd3,
    CFG_SLOT0_SIZE  = 3'd4,
    CFG_SLOT1_BASE  = 3'd5,
    CFG_SLOT1_SIZE  = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [REG_W-1:0] address;
    logic [7:0]       byte_value;
    logic [REG_W-1:0] length;
    logic             call_start;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [REG_W-1:0]   quad_address;
    logic [63:0]        data_low;
    logic [63:0]        data_high;
    logic               bank_select;
    logic [FIRST_W-1:0] first_page;
    logic [COUNT_W-1:0] page_count;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]    cnt;
    res_t [NUM_RES-1:0]      res;
  } bundle_t;

endpackage

@@ rtl/core/qwc_in_stage.sv @@
module qwc_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  qwc_pkg::item_t        in_item,
  input  logic                  take,
  output logic                  item_valid,
  output qwc_pkg::item_t        item
);
  import qwc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ rtl/core/qwc_core.sv @@
module qwc_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [qwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qwc_pkg::REG_W-1:0]      cfg_wdata,
  input  logic                           take,
  input  qwc_pkg::item_t                 item,
  output qwc_pkg::bundle_t               bundle
);
  import qwc_pkg::*;

  localparam int QW_W  = 8 * QUAD_BYTES;
  localparam int BASE_W = REG_W - QUAD_SHIFT;

  logic [REG_W-1:0] flash_start_r, meta_base_r, meta_size_r;
  logic [REG_W-1:0] slot0_base_r, slot0_size_r, slot1_base_r, slot1_size_r;

  logic [QW_W-1:0]       buf_r, buf_nxt;
  logic                  open_r, open_nxt;
  logic [BASE_W-1:0]     base_r, base_nxt;
  logic [QUAD_SHIFT-1:0] fill_r, fill_nxt;
  logic                  rej_r, rej_nxt;

  logic [REG_W-1:0] addr, len, call_end, end_m1, meta_end, slot0_end, slot1_end;
  logic             allowed;

  logic [REG_W-1:0]   off;
  logic [START_W-1:0] start_pg, room, bank1_start;
  logic [REG_W:0]     len_up;
  logic [PAGES_W-1:0] pages, run0, rem;
  logic [SUM_W-1:0]   total;
  logic               over, in_bank0, misaligned;

  logic                  go, restart, full;
  logic [QW_W-1:0]       eff_buf, new_buf;
  logic [BASE_W-1:0]     eff_base;
  logic [QUAD_SHIFT-1:0] eff_fill;
  logic [QUAD_SHIFT:0]   fill_inc;

  logic   va, vb, vc;
  res_t   ra, rb, rc, s0, s1, s2, old_flush;
  logic [RES_CNT_W-1:0] cnt;

  function automatic res_t prog_res(logic [BASE_W-1:0] base, logic [QW_W-1:0] data);
    res_t r;
    r              = '0;
    r.kind         = KIND_PROG;
    r.quad_address = {base, {QUAD_SHIFT{1'b0}}};
    r.data_low     = data[63:0];
    r.data_high    = data[127:64];
    return r;
  endfunction

  function automatic res_t run_res(logic bank, logic [FIRST_W-1:0] fp,
                                   logic [COUNT_W-1:0] pc);
    res_t r;
    r             = '0;
    r.kind        = KIND_ERASE;
    r.bank_select = bank;
    r.first_page  = fp;
    r.page_count  = pc;
    return r;
  endfunction

  function automatic res_t err_res();
    res_t r;
    r      = '0;
    r.kind = KIND_ERR;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_start_r <= 32'h0800_0000;
      meta_base_r   <= '0;
      meta_size_r   <= '0;
      slot0_base_r  <= '0;
      slot0_size_r  <= '0;
      slot1_base_r  <= '0;
      slot1_size_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FLASH_START: flash_start_r <= cfg_wdata;
        CFG_META_BASE:   meta_base_r   <= cfg_wdata;
        CFG_META_SIZE:   meta_size_r   <= cfg_wdata;
        CFG_SLOT0_BASE:  slot0_base_r  <= cfg_wdata;
        CFG_SLOT0_SIZE:  slot0_size_r  <= cfg_wdata;
        CFG_SLOT1_BASE:  slot1_base_r  <= cfg_wdata;
        CFG_SLOT1_SIZE:  slot1_size_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign addr      = item.address;
  assign len       = item.length;
  assign call_end  = addr + len;
  assign end_m1    = call_end - 1'b1;
  assign meta_end  = meta_base_r + meta_size_r;
  assign slot0_end = slot0_base_r + slot0_size_r;
  assign slot1_end = slot1_base_r + slot1_size_r;

  assign allowed =
      (addr >= meta_base_r && addr < meta_end && call_end <= meta_end) ||
      (addr >= slot0_base_r && addr < slot0_end &&
       end_m1 >= slot0_base_r && end_m1 < slot0_end) ||
      (addr >= slot1_base_r && addr < slot1_end &&
       end_m1 >= slot1_base_r && end_m1 < slot1_end);

  assign off         = addr - flash_start_r;
  assign start_pg    = off[REG_W-1:PAGE_SHIFT];
  assign len_up      = {1'b0, len} + (REG_W+1)'(PAGE_BYTES - 1);
  assign pages       = len_up[REG_W:PAGE_SHIFT];
  assign total       = SUM_W'(start_pg) + SUM_W'(pages);
  assign over        = total > SUM_W'(2 * PAGES_PER_BANK);
  assign in_bank0    = start_pg < START_W'(PAGES_PER_BANK);
  assign room        = START_W'(PAGES_PER_BANK) - start_pg;
  assign run0        = (pages < PAGES_W'(room)) ? pages : PAGES_W'(room);
  assign rem         = pages - run0;
  assign bank1_start = start_pg - START_W'(PAGES_PER_BANK);
  assign misaligned  = addr[PAGE_SHIFT-1:0] != '0;

  assign old_flush = prog_res(base_r, buf_r);
  assign restart   = !open_r || ({base_r, fill_r} != addr);
  assign eff_buf   = restart ? '1 : buf_r;
  assign eff_base  = restart ? addr[REG_W-1:QUAD_SHIFT] : base_r;
  assign eff_fill  = restart ? addr[QUAD_SHIFT-1:0] : fill_r;
  assign fill_inc  = {1'b0, eff_fill} + 1'b1;
  assign full      = fill_inc[QUAD_SHIFT];

  always_comb begin
    for (int i = 0; i < QUAD_BYTES; i++) begin
      new_buf[8*i +: 8] = (eff_fill == QUAD_SHIFT'(i)) ? item.byte_value
                                                        : eff_buf[8*i +: 8];
    end
  end

  always_comb begin
    va       = 1'b0;
    vb       = 1'b0;
    vc       = 1'b0;
    ra       = old_flush;
    rb       = err_res();
    rc       = '0;
    go       = 1'b0;
    open_nxt = open_r;
    base_nxt = base_r;
    fill_nxt = fill_r;
    buf_nxt  = buf_r;
    rej_nxt  = rej_r;
    case (item.func)
      FUNC_PROG: begin
        go = 1'b1;
        if (item.call_start) begin
          rej_nxt = 1'b0;
          if (len == '0) begin
            rej_nxt = 1'b1;
            go      = 1'b0;
          end else if (!allowed) begin
            rej_nxt = 1'b1;
            go      = 1'b0;
            vb      = 1'b1;
          end
        end else if (rej_r) begin
          go = 1'b0;
        end
        if (go) begin
          va       = open_r && restart && (fill_r != '0);
          base_nxt = eff_base;
          buf_nxt  = new_buf;
          if (full) begin
            vb       = 1'b1;
            rb       = prog_res(eff_base, new_buf);
            open_nxt = 1'b0;
            fill_nxt = '0;
          end else begin
            open_nxt = 1'b1;
            fill_nxt = fill_inc[QUAD_SHIFT-1:0];
          end
        end
      end
      FUNC_FLUSH: begin
        va       = open_r && (fill_r != '0);
        open_nxt = 1'b0;
        fill_nxt = '0;
      end
      FUNC_ERASE: begin
        if (len == '0 || !allowed) begin
          vb = 1'b1;
        end else begin
          va       = open_r && (fill_r != '0);
          open_nxt = 1'b0;
          fill_nxt = '0;
          vb       = 1'b1;
          if (misaligned || over) begin
            rb = err_res();
          end else if (in_bank0) begin
            rb = run_res(1'b0, FIRST_W'(start_pg), COUNT_W'(run0));
            vc = rem != '0;
            rc = run_res(1'b1, '0, COUNT_W'(rem));
          end else begin
            rb = run_res(1'b1, FIRST_W'(bank1_start), COUNT_W'(pages));
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    s0  = va ? ra : (vb ? rb : rc);
    s1  = va ? (vb ? rb : rc) : rc;
    s2  = rc;
    cnt = RES_CNT_W'(va) + RES_CNT_W'(vb) + RES_CNT_W'(vc);
    case (cnt)
      RES_CNT_W'(1): s0.last = 1'b1;
      RES_CNT_W'(2): s1.last = 1'b1;
      RES_CNT_W'(3): s2.last = 1'b1;
      default: ;
    endcase
    bundle.cnt = cnt;
    bundle.res = {s2, s1, s0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      fill_r <= '0;
      rej_r  <= 1'b0;
    end else if (take) begin
      open_r <= open_nxt;
      fill_r <= fill_nxt;
      rej_r  <= rej_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      base_r <= base_nxt;
      buf_r  <= buf_nxt;
    end
  end

endmodule

@@ rtl/core/qwc_out_buf.sv @@
module qwc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  qwc_pkg::bundle_t  bundle,
  output logic              load_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output qwc_pkg::res_t     out_res
);
  import qwc_pkg::*;

  res_t                 slot_r [NUM_RES];
  logic [RES_CNT_W-1:0] pend_r, pend_nxt;
  logic [RES_IDX_W-1:0] pos_r, pos_nxt;
  logic                 pop;

  assign out_valid = pend_r != '0;
  assign out_res   = slot_r[pos_r];
  assign pop       = out_valid && out_ready;
  assign load_ok   = (pend_r == '0) || (pend_r == RES_CNT_W'(1) && out_ready);

  always_comb begin
    pend_nxt = pend_r;
    pos_nxt  = pos_r;
    if (take) begin
      pend_nxt = bundle.cnt;
      pos_nxt  = '0;
    end else if (pop) begin
      pend_nxt = pend_r - 1'b1;
      pos_nxt  = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pos_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < NUM_RES; i++) begin
        slot_r[i] <= bundle.res[i];
      end
    end
  end

endmodule

@@ rtl/core/flash_quadword_write_combiner.sv @@
// Flash write front end: program bytes are packed into 16-byte quadwords
// (padded with 0xFF) and leave as program transactions; erases are checked
// and split into per-bank page runs; rejected requests give one error
// transaction, but a zero-length program call gives none. Inputs are
// registered in the input stage, results in the output buffer. An input
// yielding at most one result is taken every cycle while out_ready is high;
// one yielding two or three holds the input while the three-entry output
// buffer drains, as it reloads only when its last pending result leaves.
// Configuration must be written only while the block is idle (unenforced).
module flash_quadword_write_combiner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [qwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qwc_pkg::REG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_func,
  input  logic [31:0]                    in_address,
  input  logic [7:0]                     in_byte_value,
  input  logic [31:0]                    in_length,
  input  logic                           in_call_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_kind,
  output logic [31:0]                    out_quad_address,
  output logic [63:0]                    out_data_low,
  output logic [63:0]                    out_data_high,
  output logic                           out_bank_select,
  output logic [6:0]                     out_first_page,
  output logic [7:0]                     out_page_count,
  output logic                           out_last
);
  import qwc_pkg::*;

  item_t   in_item, item;
  logic    item_valid, take, load_ok;
  bundle_t bundle;
  res_t    out_res;

  assign in_item.func       = in_func;
  assign in_item.address    = in_address;
  assign in_item.byte_value = in_byte_value;
  assign in_item.length     = in_length;
  assign in_item.call_start = in_call_start;

  assign take = item_valid && load_ok;

  qwc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  qwc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .item      (item),
    .bundle    (bundle)
  );

  qwc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .bundle    (bundle),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_quad_address = out_res.quad_address;
  assign out_data_low     = out_res.data_low;
  assign out_data_high    = out_res.data_high;
  assign out_bank_select  = out_res.bank_select;
  assign out_first_page   = out_res.first_page;
  assign out_page_count   = out_res.page_count;
  assign out_last         = out_res.last;

  a_prog_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PROG |-> out_quad_address[QUAD_SHIFT-1:0] == '0)
    else $error("program transaction address not quadword aligned");

  a_erase_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERASE |-> out_page_count != '0 && out_quad_address == '0)
    else $error("erase run malformed");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERR |-> out_data_low == '0 && out_data_high == '0)
    else $error("error transaction carries data");

  a_take_held: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> item_valid && load_ok)
    else $error("core consumed without a held item");

endmodule
